FILE: hdl/crlf_line_ring_buffer_unit_defines.svh
// assertion macros for the line ring buffer unit
`ifndef CRLF_LINE_RING_BUFFER_UNIT_DEFINES_SVH
`define CRLF_LINE_RING_BUFFER_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CLRB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CLRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/clrb_pkg.sv
`timescale 1ns / 1ps

package clrb_pkg;

  // default geometry
  localparam int DEPTH_DEF   = 1024;
  localparam int MSG_MAX_DEF = 512;
  localparam int FILL_W      = 10;

  // line terminator characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [7:0]        out_byte;
    logic              out_valid;
    logic              line_last;
    logic              truncated;
    logic              full_res;
    logic              line_ready;
    logic [FILL_W-1:0] fill_level;
  } res_t;

endpackage

FILE: hdl/clrb_byte_ram.sv
`timescale 1ns / 1ps

module clrb_byte_ram
  import clrb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [7:0]    rdata0,
  output logic [7:0]    rdata1
);

  logic [7:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: hdl/crlf_line_ring_buffer_unit.sv
`timescale 1ns / 1ps
// channel   ports                          payload
// request   req_valid, req_ready, req      req_t: req_type, in_byte
// result    res_valid, res_ready, res      res_t: accepted .. fill_level
//
// a push never leaves ST_IDLE: the tail write needs no read, the byte before the tail is kept
// in a register for the CR LF check
// a read moves from ST_IDLE to ST_EVAL: head and head+1 are read from the byte RAM, whose read data
// is registered, and the line decision is made in ST_EVAL once the result channel is free
// reset (rst, synchronous) clears pointers, counts and flags; the byte RAM is not cleared
// a waiting result holds off the next request; one request is in flight at a time

module crlf_line_ring_buffer_unit
  import clrb_pkg::*;
#(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int MSG_MAX = MSG_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

`include "crlf_line_ring_buffer_unit_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(MSG_MAX);
  localparam logic [AW-1:0] COUNT_MAX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
  localparam logic [LW-1:0] IDX_LIMIT = LW'(MSG_MAX - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] count, count_next;
  logic [AW-1:0] term_cnt, term_cnt_next;
  logic [LW-1:0] line_idx, line_idx_next;
  logic          skip, skip_next;
  logic          skip_pair, skip_pair_next;
  logic [7:0]    last_byte;
  res_t          res_next;

  logic out_free, req_fire, push_fire, read_fire, eval_fire, push_room;
  logic [AW:0]   tail_sum, inc1_sum, inc2_sum;
  logic [AW-1:0] tail, head_inc1, head_inc2;
  logic [7:0]    rd0, rd1;
  logic          pair, cr_before_lf;
  logic [AW+FILL_W-1:0] fill_ext;

  // handshake
  assign out_free  = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req_valid && req_ready;
  assign push_fire = req_fire && (req.req_type == REQ_PUSH);
  assign read_fire = req_fire && (req.req_type == REQ_READ);
  assign eval_fire = (state == ST_EVAL) && out_free;
  assign push_room = count < COUNT_MAX;

  // ring positions, sums stay below twice the depth
  assign tail_sum  = {1'b0, head} + {1'b0, count};
  assign inc1_sum  = {1'b0, head} + (AW + 1)'(1);
  assign inc2_sum  = {1'b0, head} + (AW + 1)'(2);
  assign tail      = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
  assign head_inc1 = (inc1_sum >= DEPTH_X) ? AW'(inc1_sum - DEPTH_X) : inc1_sum[AW-1:0];
  assign head_inc2 = (inc2_sum >= DEPTH_X) ? AW'(inc2_sum - DEPTH_X) : inc2_sum[AW-1:0];

  clrb_byte_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk    (clk),
    .we     (push_fire && push_room),
    .waddr  (tail),
    .wdata  (req.in_byte),
    .re     (read_fire),
    .raddr0 (head),
    .raddr1 (head_inc1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // terminator at the head, and LF completing a CR at the tail
  assign pair         = (count >= AW'(2)) && (rd0 == CH_CR) && (rd1 == CH_LF);
  assign cr_before_lf = (req.in_byte == CH_LF) && (count >= AW'(1)) && (last_byte == CH_CR);

  // next state and result
  always_comb begin
    logic term;
    term           = 1'b0;
    state_next     = state;
    head_next      = head;
    count_next     = count;
    term_cnt_next  = term_cnt;
    line_idx_next  = line_idx;
    skip_next      = skip;
    skip_pair_next = skip_pair;
    res_next       = '0;

    if (push_fire) begin
      if (push_room) begin
        if (cr_before_lf) begin
          term_cnt_next = term_cnt + AW'(1);
          // the pair lands at the head right behind a cut line
          if (skip && (count == AW'(1))) begin
            skip_pair_next = 1'b1;
          end
        end
        count_next        = count + AW'(1);
        res_next.accepted = 1'b1;
      end
    end else if (read_fire) begin
      state_next = ST_EVAL;
    end else if (eval_fire) begin
      state_next = ST_IDLE;
      term       = skip ? 1'b0 : pair;
      if (line_idx >= IDX_LIMIT) begin
        // message limit: a terminator still ends the line normally
        res_next.line_last = 1'b1;
        if (term) begin
          head_next      = head_inc2;
          count_next     = count - AW'(2);
          term_cnt_next  = (term_cnt != '0) ? term_cnt - AW'(1) : term_cnt;
          line_idx_next  = '0;
          skip_next      = 1'b0;
          skip_pair_next = 1'b0;
        end else begin
          res_next.truncated = 1'b1;
          line_idx_next      = '0;
          skip_next          = 1'b1;
          skip_pair_next     = pair;
        end
      end else if (count != '0) begin
        skip_next      = 1'b0;
        skip_pair_next = 1'b0;
        if (term) begin
          head_next          = head_inc2;
          count_next         = count - AW'(2);
          term_cnt_next      = (term_cnt != '0) ? term_cnt - AW'(1) : term_cnt;
          line_idx_next      = '0;
          res_next.line_last = 1'b1;
        end else begin
          // a skipped pair at the head no longer counts as a terminator
          if (pair && (term_cnt != '0)) begin
            term_cnt_next = term_cnt - AW'(1);
          end
          res_next.out_byte  = rd0;
          res_next.out_valid = 1'b1;
          head_next          = head_inc1;
          count_next         = count - AW'(1);
          line_idx_next      = line_idx + LW'(1);
        end
      end
    end

    res_next.full_res   = (count_next == COUNT_MAX);
    res_next.line_ready = skip_pair_next ? (term_cnt_next >= AW'(2)) : (term_cnt_next != '0);
    res_next.fill_level = fill_ext[FILL_W-1:0];
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_next};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      term_cnt  <= '0;
      line_idx  <= '0;
      skip      <= 1'b0;
      skip_pair <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      term_cnt  <= term_cnt_next;
      line_idx  <= line_idx_next;
      skip      <= skip_next;
      skip_pair <= skip_pair_next;
      if (push_fire || eval_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push_fire || eval_fire) begin
      res <= res_next;
    end
    if (push_fire && push_room) begin
      last_byte <= req.in_byte;
    end
  end

  // checks
  `CLRB_ASSERT_ALWAYS(a_skip_pair_needs_skip, !skip_pair || skip, "pair flag without skip bit")
  `CLRB_ASSERT_ALWAYS(a_count_bound, count <= COUNT_MAX, "fill count beyond usable depth")
  `CLRB_ASSERT_ALWAYS(a_eval_blocks_req, (state != ST_EVAL) || !req_ready, "request taken mid read")
  `CLRB_ASSERT_NEXT(a_read_to_eval, read_fire, state == ST_EVAL, "read skipped evaluation")

endmodule
